@@ rtl/core/utc_to_local_time_with_eu_dst_unit_macros.svh @@
// Assertion macros for the UTC to local time unit.
`ifndef UTC_TO_LOCAL_TIME_WITH_EU_DST_UNIT_MACROS_SVH
`define UTC_TO_LOCAL_TIME_WITH_EU_DST_UNIT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define UTLD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// cons must hold in the same cycle as ante
`define UTLD_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/utld_pkg.sv @@
// Types, constants and calendar helpers for the UTC to local time unit.
package utld_pkg;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_BIT  = 2;

   typedef enum logic {
      CSR_ZONE_OFFSET = 1'b0,
      CSR_DST_ENABLE  = 1'b1
   } csr_index_type;

   localparam logic [10:0] ZONE_OFFSET_RESET = 11'd0;
   localparam logic        DST_ENABLE_RESET  = 1'b1;

   localparam logic [3:0]  DST_START_MONTH   = 4'd3;
   localparam logic [3:0]  DST_END_MONTH     = 4'd10;
   localparam logic [4:0]  DST_SWITCH_HOUR   = 5'd1;
   localparam logic [12:0] DST_SHIFT_MINUTES = 13'd60;
   localparam logic [12:0] MINUTES_PER_DAY   = 13'd1440;

   typedef struct packed {
      logic [11:0] utc_year;
      logic [3:0]  utc_month;
      logic [4:0]  utc_day;
      logic [4:0]  utc_hour;
      logic [5:0]  utc_minute;
      logic [5:0]  utc_second;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] local_year;
      logic [3:0]  local_month;
      logic [4:0]  local_day;
      logic [4:0]  local_hour;
      logic [5:0]  local_minute;
      logic [5:0]  local_second;
      logic        in_dst;
   } rsp_payload_type;

   // month 1..12; February follows the leap flag
   function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // weekday key of a month, for the weekday of day 31
   function automatic logic [2:0] month_key(input logic [3:0] month);
      logic [2:0] key;
      case (month)
         4'd1:    key = 3'd0;
         4'd2:    key = 3'd3;
         4'd3:    key = 3'd2;
         4'd4:    key = 3'd5;
         4'd5:    key = 3'd0;
         4'd6:    key = 3'd3;
         4'd7:    key = 3'd5;
         4'd8:    key = 3'd1;
         4'd9:    key = 3'd4;
         4'd10:   key = 3'd6;
         4'd11:   key = 3'd2;
         4'd12:   key = 3'd4;
         default: key = 3'd0;
      endcase
      return key;
   endfunction

   // (r + k) mod 7 for r, k in 0..6
   function automatic logic [2:0] add_mod7(input logic [2:0] r, input logic [2:0] k);
      logic [3:0] s;
      s = {1'b0, r} + {1'b0, k};
      return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
   endfunction

endpackage

@@ rtl/core/utld_channels_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
interface utld_req_if;
   logic                      valid;
   logic                      ready;
   utld_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface utld_rsp_if;
   logic                      valid;
   logic                      ready;
   utld_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/utc_to_local_time_with_eu_dst_unit.sv @@
// UTC to local time unit: converts a UTC calendar time (year, month, day, hour,
// minute, second) into official local time by adding the zone offset and, with
// the European rule enabled, one more hour from the last Sunday of March 01:00
// UTC up to (not including) the last Sunday of October 01:00 UTC. Day, month
// and year carries follow the Gregorian calendar. Out-of-range input fields are
// clamped (month 1..12, day 1..month length, hour 23, minute and second 59).
// Throughput is one beat per clock while the response side accepts; the pipe
// has seven register stages (year/100, leap and weekday base, weekday multiply,
// DST window compare, minute sum, day carry, minute split). Each stage has its
// own valid bit and enable, so bubbles collapse and a stalled response only
// backs up the pipe once every stage is full. Registers on the APB-style port:
// 0x0 zone_offset_minutes (11-bit signed, reset 0), 0x4 dst_enable (reset 1).
// Write them only while the pipe is empty.
`include "utc_to_local_time_with_eu_dst_unit_macros.svh"

module utc_to_local_time_with_eu_dst_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   utld_req_if.sink                             req_chan,
   utld_rsp_if.source                           rsp_chan,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [utld_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [utld_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [utld_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready
);

   localparam int NUM_STAGES = 7;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   typedef struct packed {
      date_type    date;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } time_fields_type;

   typedef struct packed {
      time_fields_type tf;
      logic [5:0]      q100;     // year / 100
   } st1_type;

   typedef struct packed {
      time_fields_type tf;
      logic            leap;
      logic [12:0]     base;     // weekday sum of day 31 before the month key
   } st2_type;

   typedef struct packed {
      time_fields_type tf;
      logic            leap;
      logic [12:0]     base;
      logic [9:0]      q7;       // base / 7
   } st3_type;

   typedef struct packed {
      time_fields_type tf;
      logic            leap;
      logic            dst;
   } st4_type;

   typedef struct packed {
      date_type    date;
      logic [5:0]  second;
      logic        leap;
      logic        dst;
      logic [12:0] total;        // two's complement minute of day, before carry
   } st5_type;

   typedef struct packed {
      date_type    date;
      logic [5:0]  second;
      logic        dst;
      logic [10:0] tadj;         // minute of day 0..1439
      logic [4:0]  q60;          // tadj / 60
   } st6_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [10:0] zone_offset_ff;
   logic        dst_enable_ff;
   utld_pkg::csr_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_index = utld_pkg::csr_index_type'(paddr[utld_pkg::CSR_INDEX_BIT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_offset_ff <= utld_pkg::ZONE_OFFSET_RESET;
         dst_enable_ff  <= utld_pkg::DST_ENABLE_RESET;
      end else if (psel && penable && pwrite && pready) begin
         unique case (csr_index)
            utld_pkg::CSR_ZONE_OFFSET: zone_offset_ff <= pwdata[10:0];
            utld_pkg::CSR_DST_ENABLE:  dst_enable_ff  <= pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         utld_pkg::CSR_ZONE_OFFSET:
            prdata = {{(utld_pkg::CSR_DATA_WIDTH-11){zone_offset_ff[10]}}, zone_offset_ff};
         utld_pkg::CSR_DST_ENABLE:
            prdata = {{(utld_pkg::CSR_DATA_WIDTH-1){1'b0}}, dst_enable_ff};
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or the next one loads
   // ---------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_en;

   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in = {valid_ff[NUM_STAGES-2:0], req_chan.valid};
   end

   assign req_chan.ready = stage_en[0];
   assign rsp_chan.valid = valid_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: clamp fields, year / 100 by reciprocal (5243 / 2^19)
   // ---------------------------------------------------------------------
   st1_type     s1_in, s1_ff;
   logic [24:0] p100;

   always_comb begin
      s1_in.tf.date.year = req_chan.payload.utc_year;
      if (req_chan.payload.utc_month == 4'd0) begin
         s1_in.tf.date.month = 4'd1;
      end else if (req_chan.payload.utc_month > 4'd12) begin
         s1_in.tf.date.month = 4'd12;
      end else begin
         s1_in.tf.date.month = req_chan.payload.utc_month;
      end
      s1_in.tf.date.day = req_chan.payload.utc_day;   // clamped once leap is known
      s1_in.tf.hour   = (req_chan.payload.utc_hour > 5'd23) ? 5'd23
                                                            : req_chan.payload.utc_hour;
      s1_in.tf.minute = (req_chan.payload.utc_minute > 6'd59) ? 6'd59
                                                              : req_chan.payload.utc_minute;
      s1_in.tf.second = (req_chan.payload.utc_second > 6'd59) ? 6'd59
                                                              : req_chan.payload.utc_second;
      p100       = 25'(req_chan.payload.utc_year) * 25'd5243;
      s1_in.q100 = p100[24:19];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: leap year, day clamp, weekday base sum
   //   base = y + y/4 - y/100 + y/400 + 31
   // ---------------------------------------------------------------------
   st2_type    s2_in, s2_ff;
   logic [6:0] rem100;
   logic [4:0] dim1;

   always_comb begin
      rem100     = 7'(13'(s1_ff.tf.date.year) - 13'(s1_ff.q100) * 13'd100);
      s2_in.tf   = s1_ff.tf;
      s2_in.leap = ((s1_ff.tf.date.year[1:0] == 2'd0) && (rem100 != 7'd0)) ||
                   ((rem100 == 7'd0) && (s1_ff.q100[1:0] == 2'd0));
      dim1       = utld_pkg::days_in_month(s1_ff.tf.date.month, s2_in.leap);
      if (s1_ff.tf.date.day == 5'd0) begin
         s2_in.tf.date.day = 5'd1;
      end else if (s1_ff.tf.date.day > dim1) begin
         s2_in.tf.date.day = dim1;
      end
      s2_in.base = 13'(s1_ff.tf.date.year) + 13'(s1_ff.tf.date.year[11:2])
                 - 13'(s1_ff.q100) + 13'(s1_ff.q100[5:2]) + 13'd31;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: base / 7 by reciprocal (37450 / 2^18, exact below 8192)
   // ---------------------------------------------------------------------
   st3_type     s3_in, s3_ff;
   logic [27:0] p7;

   always_comb begin
      s3_in.tf   = s2_ff.tf;
      s3_in.leap = s2_ff.leap;
      s3_in.base = s2_ff.base;
      p7         = 28'(s2_ff.base) * 28'd37450;
      s3_in.q7   = p7[27:18];
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: last Sundays of March and October, DST window compare
   // ---------------------------------------------------------------------
   st4_type     s4_in, s4_ff;
   logic [2:0]  r7;
   logic [2:0]  wd_start, wd_end;
   logic [4:0]  sun_start, sun_end;
   logic [25:0] now_key, start_key, stop_key;

   always_comb begin
      r7        = 3'(s3_ff.base - 13'(s3_ff.q7) * 13'd7);
      wd_start  = utld_pkg::add_mod7(r7, utld_pkg::month_key(utld_pkg::DST_START_MONTH));
      wd_end    = utld_pkg::add_mod7(r7, utld_pkg::month_key(utld_pkg::DST_END_MONTH));
      sun_start = 5'd31 - 5'(wd_start);
      sun_end   = 5'd31 - 5'(wd_end);
      now_key   = {s3_ff.tf.date.month, s3_ff.tf.date.day, s3_ff.tf.hour,
                   s3_ff.tf.minute, s3_ff.tf.second};
      start_key = {utld_pkg::DST_START_MONTH, sun_start, utld_pkg::DST_SWITCH_HOUR,
                   6'd0, 6'd0};
      stop_key  = {utld_pkg::DST_END_MONTH, sun_end, utld_pkg::DST_SWITCH_HOUR,
                   6'd0, 6'd0};
      s4_in.tf   = s3_ff.tf;
      s4_in.leap = s3_ff.leap;
      s4_in.dst  = dst_enable_ff && (now_key >= start_key) && (now_key < stop_key);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_ff <= s4_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: minute of day plus offset plus DST hour (range -1024..2522)
   // ---------------------------------------------------------------------
   st5_type     s5_in, s5_ff;
   logic [10:0] hm;

   always_comb begin
      hm           = 11'(s4_ff.tf.hour) * 11'd60 + 11'(s4_ff.tf.minute);
      s5_in.date   = s4_ff.tf.date;
      s5_in.second = s4_ff.tf.second;
      s5_in.leap   = s4_ff.leap;
      s5_in.dst    = s4_ff.dst;
      s5_in.total  = 13'(hm) + {{2{zone_offset_ff[10]}}, zone_offset_ff}
                   + (s4_ff.dst ? utld_pkg::DST_SHIFT_MINUTES : 13'd0);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s5_ff <= s5_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: day carry or borrow, hour by reciprocal (1093 / 2^16)
   // ---------------------------------------------------------------------
   st6_type     s6_in, s6_ff;
   logic        borrow, carry;
   logic [12:0] tfix;
   logic [4:0]  dim_cur, dim_prev;
   logic [20:0] p60;

   always_comb begin
      borrow   = s5_ff.total[12];
      carry    = !borrow && (s5_ff.total >= utld_pkg::MINUTES_PER_DAY);
      dim_cur  = utld_pkg::days_in_month(s5_ff.date.month, s5_ff.leap);
      dim_prev = utld_pkg::days_in_month(s5_ff.date.month - 4'd1, s5_ff.leap);
      s6_in.date   = s5_ff.date;
      s6_in.second = s5_ff.second;
      s6_in.dst    = s5_ff.dst;
      tfix         = s5_ff.total;
      if (borrow) begin
         tfix = s5_ff.total + utld_pkg::MINUTES_PER_DAY;
         if (s5_ff.date.day > 5'd1) begin
            s6_in.date.day = s5_ff.date.day - 5'd1;
         end else if (s5_ff.date.month > 4'd1) begin
            s6_in.date.month = s5_ff.date.month - 4'd1;
            s6_in.date.day   = dim_prev;
         end else begin
            s6_in.date.month = 4'd12;
            s6_in.date.day   = 5'd31;
            s6_in.date.year  = s5_ff.date.year - 12'd1;
         end
      end else if (carry) begin
         tfix = s5_ff.total - utld_pkg::MINUTES_PER_DAY;
         if (s5_ff.date.day < dim_cur) begin
            s6_in.date.day = s5_ff.date.day + 5'd1;
         end else begin
            s6_in.date.day = 5'd1;
            if (s5_ff.date.month < 4'd12) begin
               s6_in.date.month = s5_ff.date.month + 4'd1;
            end else begin
               s6_in.date.month = 4'd1;
               s6_in.date.year  = s5_ff.date.year + 12'd1;
            end
         end
      end
      s6_in.tadj = tfix[10:0];
      p60        = 21'(tfix[10:0]) * 21'd1093;
      s6_in.q60  = p60[20:16];
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s6_ff <= s6_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 7: minute remainder, output register
   // ---------------------------------------------------------------------
   utld_pkg::rsp_payload_type s7_in, s7_ff;

   always_comb begin
      s7_in.local_year   = s6_ff.date.year;
      s7_in.local_month  = s6_ff.date.month;
      s7_in.local_day    = s6_ff.date.day;
      s7_in.local_hour   = s6_ff.q60;
      s7_in.local_minute = 6'(s6_ff.tadj - 11'(s6_ff.q60) * 11'd60);
      s7_in.local_second = s6_ff.second;
      s7_in.in_dst       = s6_ff.dst;
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         s7_ff <= s7_in;
      end
   end

   assign rsp_chan.payload = s7_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `UTLD_ASSERT_IMPLIES(a_dst_needs_enable, rsp_chan.valid && rsp_chan.payload.in_dst, dst_enable_ff, "DST beat while rule disabled")
   `UTLD_ASSERT_IMPLIES(a_time_in_range, rsp_chan.valid, (rsp_chan.payload.local_hour < 5'd24) && (rsp_chan.payload.local_minute < 6'd60), "local time out of range")
   `UTLD_ASSERT_IMPLIES(a_stall_only_when_full, !req_chan.ready, &valid_ff, "request stalled with a bubble in the pipe")

endmodule
